/* src/plr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

   // configuration port
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic REG_EPSILON = 1'b0;

   // epsilon as a fraction of 2^16
   localparam int EPS_BITS = 17;
   localparam logic [EPS_BITS-1:0] EPS_ONE = 17'd65536;
   localparam logic [EPS_BITS-1:0] EPS_RESET = 17'd6554;

   // log2 unit: normalize, shift, then one fraction bit per squaring stage
   localparam int FRAC_BITS = 32;
   localparam int LOG_STAGES = FRAC_BITS + 2;

   // round(10*log10(2)*2^32)
   localparam int K_BITS = 34;
   localparam logic [K_BITS-1:0] DB_PER_LOG2 = 34'd12929139865;

   // per-term clamp and output range
   localparam logic [63:0] TERM_CLAMP = 64'h1000_0000_0000_0000;
   localparam int OUT_BITS = 40;
   localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
   localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

endpackage

`default_nettype wire

/* src/plr_log2.sv */
`timescale 1ns / 1ps
`default_nettype none

module plr_log2 #(
   parameter int W = 38
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [W-1:0]          x,
   output logic [$clog2(W)+31:0] l
);

   localparam int PB = $clog2(W);
   localparam int FB = plr_pkg::FRAC_BITS;

   // position of the leading one
   function automatic logic [PB-1:0] msb_pos(input logic [W-1:0] v);
      logic [PB-1:0] pos;
      pos = '0;
      for (int i = 0; i < W; i++) begin
         if (v[i]) begin
            pos = PB'(i);
         end
      end
      return pos;
   endfunction

   logic [W-1:0]  x_ff;
   logic [PB-1:0] p_ff [0:FB+1];
   logic [FB-1:0] y_ff [0:FB];
   logic [FB-1:0] f_ff [1:FB];
   logic [W-1:0]  norm;

   // leading one search
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x;
         p_ff[0] <= msb_pos(x);
      end
   end

   // shift the leading one to the top, keep 32 bits as Q1.31
   assign norm = x_ff << (PB'(W - 1) - p_ff[0]);

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= norm[W-1 -: FB];
         p_ff[1] <= p_ff[0];
      end
   end

   // one fraction bit per squaring stage
   for (genvar j = 0; j < FB; j++) begin : g_step
      logic [2*FB-1:0] sq;
      logic [FB:0]     t;
      logic [FB-1:0]   f_prev;

      assign sq = y_ff[j] * y_ff[j];
      assign t = sq[2*FB-1:FB-1];
      if (j == 0) begin : g_first
         assign f_prev = '0;
      end else begin : g_next
         assign f_prev = f_ff[j];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            y_ff[j+1] <= t[FB] ? t[FB:1] : t[FB-1:0];
            f_ff[j+1] <= {f_prev[FB-2:0], t[FB]};
            p_ff[j+2] <= p_ff[j+1];
         end
      end
   end

   assign l = {p_ff[FB+1], f_ff[FB]};

endmodule

`default_nettype wire

/* src/phase_log_likelihood_ratio_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  handshake              payload
// req        in         req_valid / req_stall  req_count_00/01/10/11
// rsp        out        rsp_valid / rsp_stall  rsp_log_in_phase, rsp_log_out_phase, rsp_valid_res
// csr        in/out     apb write/read         epsilon at byte address 0
//
// one item per cycle while no result is held by rsp_stall; the pipeline is built from the
// 34-stage log2 units (five side by side) and the multiply stages around them.
// synchronous active-high reset clears valid bits and sets epsilon to 6554.
// a stalled result holds the whole pipeline; req_stall is high only then.

module phase_log_likelihood_ratio_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [COUNT_BITS-1:0]                  req_count_00,
   input  logic [COUNT_BITS-1:0]                  req_count_01,
   input  logic [COUNT_BITS-1:0]                  req_count_10,
   input  logic [COUNT_BITS-1:0]                  req_count_11,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [plr_pkg::OUT_BITS-1:0]    rsp_log_in_phase,
   output logic signed [plr_pkg::OUT_BITS-1:0]    rsp_log_out_phase,
   output logic                                   rsp_valid_res,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [plr_pkg::ADDR_BITS-1:0]          csr_paddr,
   input  logic [plr_pkg::DATA_BITS-1:0]          csr_pwdata,
   output logic [plr_pkg::DATA_BITS-1:0]          csr_prdata,
   output logic                                   csr_pready
);

   localparam int CB = COUNT_BITS;
   localparam int EW = plr_pkg::EPS_BITS;
   localparam int SW = CB + 1;
   localparam int NW = CB + 2;
   localparam int N2W = 2 * NW;
   localparam int DW = 2 * SW + 1;
   localparam int LW = N2W + EW + 1;
   localparam int PB = $clog2(LW);
   localparam int LVW = PB + plr_pkg::FRAC_BITS;
   localparam int DSW = LVW + 2;
   localparam int MW = LVW + 1;
   localparam int KW = plr_pkg::K_BITS;
   localparam int MLW = 32 + KW;
   localparam int MHW = MW - 32 + KW;
   localparam int PERW = MW + 3;
   localparam int PHW = PERW - 32;
   localparam int TW = CB + PERW + 1;
   localparam int NS = 48;

   typedef struct packed {
      logic [CB-1:0] c00;
      logic [CB-1:0] c01;
      logic [CB-1:0] c10;
      logic [CB-1:0] c11;
      logic [EW-1:0] eps;
   } side_type;

   localparam logic [DSW-1:0] OFF16 = DSW'(64'd16 << 32);

   logic en;
   logic [NS-1:0] v_ff;
   side_type sb_ff [0:NS-2];
   logic [EW-1:0] eps_ff;
   logic [EW-1:0] eps_clamp;
   logic csr_write;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == plr_pkg::REG_EPSILON) ?
                       plr_pkg::DATA_BITS'(eps_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= plr_pkg::EPS_RESET;
      end else if (csr_write && csr_paddr[2] == plr_pkg::REG_EPSILON) begin
         eps_ff <= csr_pwdata[EW-1:0];
      end
   end

   // pipeline advance and valid bits
   assign en = !(v_ff[NS-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
   end

   // counts and epsilon travel with the item
   assign eps_clamp = (eps_ff > plr_pkg::EPS_ONE) ? plr_pkg::EPS_ONE : eps_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= '{c00: req_count_00, c01: req_count_01,
                       c10: req_count_10, c11: req_count_11, eps: eps_clamp};
         for (int k = 1; k < NS - 1; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // row and column sums
   logic [SW-1:0] n0a_ff, n0b_ff, n1a_ff, n1b_ff;
   logic [NW-1:0] n_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n0a_ff <= SW'(sb_ff[0].c00) + SW'(sb_ff[0].c01);
         n0b_ff <= SW'(sb_ff[0].c10) + SW'(sb_ff[0].c11);
         n1a_ff <= SW'(sb_ff[0].c00) + SW'(sb_ff[0].c10);
         n1b_ff <= SW'(sb_ff[0].c01) + SW'(sb_ff[0].c11);
         n_ff <= NW'(sb_ff[0].c00) + NW'(sb_ff[0].c01)
               + NW'(sb_ff[0].c10) + NW'(sb_ff[0].c11);
      end
   end

   // products
   logic [N2W-1:0] n2_ff;
   logic [2*SW-1:0] pia_ff, pib_ff, poa_ff, pob_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff <= n_ff * n_ff;
         pia_ff <= n0a_ff * n1a_ff;
         pib_ff <= n0b_ff * n1b_ff;
         poa_ff <= n0a_ff * n1b_ff;
         pob_ff <= n0b_ff * n1a_ff;
      end
   end

   // matching product sums
   logic [DW-1:0] din_ff [3:5];
   logic [DW-1:0] dout_ff [3:5];
   logic [N2W-1:0] n2b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         din_ff[3] <= DW'(pia_ff) + DW'(pib_ff);
         dout_ff[3] <= DW'(poa_ff) + DW'(pob_ff);
         n2b_ff <= n2_ff;
         din_ff[4] <= din_ff[3];
         dout_ff[4] <= dout_ff[3];
         din_ff[5] <= din_ff[4];
         dout_ff[5] <= dout_ff[4];
      end
   end

   // eps*D and (1-eps)*n^2
   logic [DW+EW-1:0] nia_ff, noa_ff;
   logic [N2W+EW-1:0] nib_ff, nob_ff;
   logic [EW-1:0] one_m_eps;

   assign one_m_eps = plr_pkg::EPS_ONE - sb_ff[3].eps;

   always_ff @(posedge clock) begin
      if (en) begin
         nia_ff <= din_ff[3] * sb_ff[3].eps;
         noa_ff <= dout_ff[3] * sb_ff[3].eps;
         nib_ff <= n2b_ff * one_m_eps;
         nob_ff <= n2b_ff * one_m_eps;
      end
   end

   // numerators
   logic [LW-1:0] num_in_ff, num_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num_in_ff <= LW'(nia_ff) + LW'(nib_ff);
         num_out_ff <= LW'(noa_ff) + LW'(nob_ff);
      end
   end

   // five log2 units
   logic [LVW-1:0] l_num_in, l_din, l_num_out, l_dout, l_eps;

   plr_log2 #(.W(LW)) u_log_num_in (
      .clock(clock), .en(en), .x(num_in_ff), .l(l_num_in));
   plr_log2 #(.W(LW)) u_log_din (
      .clock(clock), .en(en), .x(LW'(din_ff[5])), .l(l_din));
   plr_log2 #(.W(LW)) u_log_num_out (
      .clock(clock), .en(en), .x(num_out_ff), .l(l_num_out));
   plr_log2 #(.W(LW)) u_log_dout (
      .clock(clock), .en(en), .x(LW'(dout_ff[5])), .l(l_dout));
   plr_log2 #(.W(LW)) u_log_eps (
      .clock(clock), .en(en), .x(LW'(sb_ff[5].eps)), .l(l_eps));

   // log2 ratios: lane 0 in-phase diagonal, 1 out-of-phase diagonal, 2 off-diagonal
   logic [DSW-1:0] d_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= DSW'(l_num_in) - DSW'(l_din) - OFF16;
         d_ff[1] <= DSW'(l_num_out) - DSW'(l_dout) - OFF16;
         d_ff[2] <= DSW'(l_eps) - OFF16;
      end
   end

   // magnitude and sign
   logic [MW-1:0] mag_ff [0:2];
   logic [2:0] neg_ff [41:44];
   logic [DSW-1:0] d_neg [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_neg[k] = -d_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            neg_ff[41][k] <= d_ff[k][DSW-1];
            mag_ff[k] <= d_ff[k][DSW-1] ? d_neg[k][MW-1:0] : d_ff[k][MW-1:0];
         end
         neg_ff[42] <= neg_ff[41];
         neg_ff[43] <= neg_ff[42];
         neg_ff[44] <= neg_ff[43];
      end
   end

   // decibels per count: partial products with 10*log10(2)
   logic [MLW-1:0] mlo_ff [0:2];
   logic [MHW-1:0] mhi_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            mlo_ff[k] <= mag_ff[k][31:0] * plr_pkg::DB_PER_LOG2;
            mhi_ff[k] <= mag_ff[k][MW-1:32] * plr_pkg::DB_PER_LOG2;
         end
      end
   end

   logic [PERW-1:0] per_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            per_ff[k] <= PERW'(mhi_ff[k]) + PERW'(mlo_ff[k][MLW-1:32]);
         end
      end
   end

   // count times per-count value, eight terms
   logic [CB-1:0] t_cnt [0:7];
   logic [1:0] t_lane [0:7];
   logic [CB+31:0] plo_ff [0:7];
   logic [CB+PHW-1:0] phi_ff [0:7];

   always_comb begin
      t_cnt[0] = sb_ff[43].c00;  t_lane[0] = 2'd0;
      t_cnt[1] = sb_ff[43].c11;  t_lane[1] = 2'd0;
      t_cnt[2] = sb_ff[43].c01;  t_lane[2] = 2'd2;
      t_cnt[3] = sb_ff[43].c10;  t_lane[3] = 2'd2;
      t_cnt[4] = sb_ff[43].c01;  t_lane[4] = 2'd1;
      t_cnt[5] = sb_ff[43].c10;  t_lane[5] = 2'd1;
      t_cnt[6] = sb_ff[43].c00;  t_lane[6] = 2'd2;
      t_cnt[7] = sb_ff[43].c11;  t_lane[7] = 2'd2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 8; j++) begin
            plo_ff[j] <= t_cnt[j] * per_ff[t_lane[j]][31:0];
            phi_ff[j] <= t_cnt[j] * per_ff[t_lane[j]][PERW-1:32];
         end
      end
   end

   // round to 8 fraction bits, clamp, apply sign
   logic [TW-1:0] tsum [0:7];
   logic [63:0] tmag [0:7];
   logic [60:0] tclamp [0:7];
   logic signed [63:0] term_ff [0:7];

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         tsum[j] = TW'(plo_ff[j]) + (TW'(phi_ff[j]) << 32) + TW'(64'd1 << 23);
         tmag[j] = 64'(tsum[j][TW-1:24]);
         tclamp[j] = (tmag[j] > plr_pkg::TERM_CLAMP) ? plr_pkg::TERM_CLAMP[60:0]
                                                      : tmag[j][60:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 8; j++) begin
            term_ff[j] <= neg_ff[44][t_lane[j]] ? -$signed(64'(tclamp[j]))
                                                 : $signed(64'(tclamp[j]));
         end
      end
   end

   // pair sums
   logic signed [63:0] ps_ff [0:3];

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff[0] <= term_ff[0] + term_ff[1];
         ps_ff[1] <= term_ff[2] + term_ff[3];
         ps_ff[2] <= term_ff[4] + term_ff[5];
         ps_ff[3] <= term_ff[6] + term_ff[7];
      end
   end

   // final sums, saturation and special cases
   logic signed [63:0] sum_in, sum_out;
   logic n_zero, eps_zero, off_in, off_out;
   logic signed [plr_pkg::OUT_BITS-1:0] res_in, res_out;
   logic signed [plr_pkg::OUT_BITS-1:0] log_in_ff, log_out_ff;
   logic valid_res_ff;

   always_comb begin
      sum_in = ps_ff[0] + ps_ff[1];
      sum_out = ps_ff[2] + ps_ff[3];
      n_zero = (sb_ff[NS-2].c00 | sb_ff[NS-2].c01 |
                sb_ff[NS-2].c10 | sb_ff[NS-2].c11) == '0;
      eps_zero = sb_ff[NS-2].eps == '0;
      off_in = (sb_ff[NS-2].c01 | sb_ff[NS-2].c10) != '0;
      off_out = (sb_ff[NS-2].c00 | sb_ff[NS-2].c11) != '0;

      if (n_zero) begin
         res_in = '0;
      end else if (eps_zero && off_in) begin
         res_in = plr_pkg::OUT_MIN[plr_pkg::OUT_BITS-1:0];
      end else if (sum_in > plr_pkg::OUT_MAX) begin
         res_in = plr_pkg::OUT_MAX[plr_pkg::OUT_BITS-1:0];
      end else if (sum_in < plr_pkg::OUT_MIN) begin
         res_in = plr_pkg::OUT_MIN[plr_pkg::OUT_BITS-1:0];
      end else begin
         res_in = sum_in[plr_pkg::OUT_BITS-1:0];
      end

      if (n_zero) begin
         res_out = '0;
      end else if (eps_zero && off_out) begin
         res_out = plr_pkg::OUT_MIN[plr_pkg::OUT_BITS-1:0];
      end else if (sum_out > plr_pkg::OUT_MAX) begin
         res_out = plr_pkg::OUT_MAX[plr_pkg::OUT_BITS-1:0];
      end else if (sum_out < plr_pkg::OUT_MIN) begin
         res_out = plr_pkg::OUT_MIN[plr_pkg::OUT_BITS-1:0];
      end else begin
         res_out = sum_out[plr_pkg::OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         log_in_ff <= res_in;
         log_out_ff <= res_out;
         valid_res_ff <= !n_zero;
      end
   end

   assign rsp_log_in_phase = log_in_ff;
   assign rsp_log_out_phase = log_out_ff;
   assign rsp_valid_res = valid_res_ff;

   // input side waits only behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // an empty matrix gives zero ratios
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
      (rsp_log_in_phase == '0 && rsp_log_out_phase == '0))
      else $error("empty matrix gave nonzero ratio");

   // epsilon of one makes every log ratio vanish
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && eps_ff >= plr_pkg::EPS_ONE) |->
      (rsp_log_in_phase == '0 && rsp_log_out_phase == '0))
      else $error("full mixing gave nonzero ratio");

   // the pipeline holds while the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(v_ff))
      else $error("pipeline moved under a stall");

endmodule

`default_nettype wire
